@@ hw/rtl/acv_pkg.sv @@
// shared types and constants for the ac voltage period classifier
`default_nettype none
package acv_pkg;

  // fixed field widths
  localparam int VAL_W   = 16;
  localparam int SUM_W   = 20;
  localparam int VOLT_W  = 8;
  localparam int IDX_W   = 7;
  localparam int CMD_W   = 2;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 16;

  // input commands
  localparam logic [CMD_W-1:0] CMD_LOAD     = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CAPTURE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_OVERFLOW = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NO_EDGE  = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_REF_OFFSET = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_NOMINAL    = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_HIGH_LIMIT = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_LOW_LIMIT  = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_MIN_PERIOD = 3'd4;

  // reset values of the configuration registers
  localparam logic [VOLT_W-1:0] RST_REF_OFFSET = 8'd151;
  localparam logic [VOLT_W-1:0] RST_NOMINAL    = 8'd220;
  localparam logic [VOLT_W-1:0] RST_HIGH_LIMIT = 8'd223;
  localparam logic [VOLT_W-1:0] RST_LOW_LIMIT  = 8'd217;
  localparam logic [VAL_W-1:0]  RST_MIN_PERIOD = 16'd768;

  // reading forced by a timeout event
  localparam logic [VOLT_W-1:0] TIMEOUT_VOLTS = 8'd150;

  // outcome of a table search
  typedef struct packed {
    logic             match;
    logic             rnd_down;
    logic [IDX_W-1:0] idx;
  } srch_res_t;

endpackage
`default_nettype wire

@@ hw/rtl/acv_div.sv @@
// divide of the window sum by a constant through a scaled reciprocal multiply
`default_nettype none
module acv_div #(
  parameter int DIVISOR = 10
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [acv_pkg::SUM_W-1:0] dividend,
  output logic                           done,
  output logic [acv_pkg::VAL_W-1:0]      quotient
);
  import acv_pkg::*;

  // reciprocal scaled by 2^SHIFT, rounded up; exact for every SUM_W-bit dividend
  localparam int SHIFT   = SUM_W + $clog2(DIVISOR);
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** SHIFT + DIVISOR - 1) / DIVISOR);

  logic               busy_r;
  logic               done_r;
  logic [SUM_W-1:0]   dvd_r;
  logic [VAL_W-1:0]   q_r;
  logic [PROD_W-1:0]  prod;

  // dividend times the scaled reciprocal
  assign prod = PROD_W'(dvd_r) * PROD_W'(RECIP);

  // control: capture on start, quotient in the cycle after the capture
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= start;
      done_r <= busy_r;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
    end
    if (busy_r) begin
      q_r <= prod[SHIFT +: VAL_W];
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule
`default_nettype wire

@@ hw/rtl/acv_search.sv @@
// calibration table memory and sequential first-at-or-above search
`default_nettype none
module acv_search #(
  parameter int TABLE_DEPTH = 100
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      wr_en,
  input  wire logic [acv_pkg::IDX_W-1:0] wr_idx,
  input  wire logic [acv_pkg::VAL_W-1:0] wr_data,
  input  wire logic                      start,
  input  wire logic [acv_pkg::VAL_W-1:0] mean,
  output logic                           done,
  output acv_pkg::srch_res_t             res
);
  import acv_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(TABLE_DEPTH - 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_PRIME = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;

  logic [VAL_W-1:0]  mem [TABLE_DEPTH];
  logic [VAL_W-1:0]  rd_data_r;
  logic [ADDR_W-1:0] rd_addr;

  logic [1:0]        state_r;
  logic [ADDR_W-1:0] idx_r;
  logic [VAL_W-1:0]  mean_r;
  logic [VAL_W-1:0]  prev_r;
  logic              done_r;
  srch_res_t         res_r;

  logic              hit;
  logic              nearer_below;

  // table memory, one write and one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx[ADDR_W-1:0]] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // read one entry ahead while scanning
  assign rd_addr = (state_r == S_SCAN && idx_r != LAST) ? idx_r + ADDR_W'(1) : idx_r;

  // compare current entry and rounding against the one below
  assign hit          = (mean_r <= rd_data_r);
  assign nearer_below = (idx_r != '0) && ((rd_data_r - mean_r) > (mean_r - prev_r));

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
      idx_r   <= '0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            idx_r   <= '0;
            state_r <= S_PRIME;
          end
        end
        S_PRIME: begin
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (hit || idx_r == LAST) begin
            done_r  <= 1'b1;
            state_r <= S_IDLE;
          end else begin
            idx_r <= idx_r + ADDR_W'(1);
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (start && state_r == S_IDLE) begin
      mean_r <= mean;
    end
    if (state_r == S_SCAN) begin
      prev_r         <= rd_data_r;
      res_r.match    <= hit;
      res_r.rnd_down <= hit && nearer_below;
      res_r.idx      <= IDX_W'(idx_r);
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule
`default_nettype wire

@@ hw/rtl/ac_voltage_period_classifier_top.sv @@
// top level: command decode, moving window, sequencer and classification
//
// Usage: items enter on in_valid/in_stall with fields in_cmd, in_index and
// in_value. A table load writes one calibration entry when in_index is below
// TABLE_DEPTH and gives no result; a capture below min_period gives no result.
// A valid capture gives one reading after these steps in order: the
// reciprocal divide by WINDOW_LEN, priming the table read, the scan of
// 1..TABLE_DEPTH table entries at one entry per cycle, and forming and
// classifying the reading.
// A timeout item gives a result of 150 once the output register is free.
// One item is in work at a time; in_stall is high from acceptance until the
// result is placed in the output register. Table loads leave in_stall low.
// Results are held in an output register until out_stall is low; while the
// receiver stalls and a new result is ready, the block waits and holds
// in_stall high. Configuration is written through cfg_we, cfg_index and
// cfg_wdata; the user must write it only while idle, the block itself does
// not enforce this. Synchronous reset clears the window, the flags and the
// configuration to defaults; table contents are undefined until loaded.
`default_nettype none
module ac_voltage_period_classifier_top #(
  parameter int TABLE_DEPTH = 100,
  parameter int WINDOW_LEN  = 10
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // configuration
  input  wire logic                        cfg_we,
  input  wire logic [acv_pkg::CFG_IW-1:0]  cfg_index,
  input  wire logic [acv_pkg::CFG_DW-1:0]  cfg_wdata,
  // input items
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [acv_pkg::CMD_W-1:0]   in_cmd,
  input  wire logic [acv_pkg::IDX_W-1:0]   in_index,
  input  wire logic [acv_pkg::VAL_W-1:0]   in_value,
  // result items
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [acv_pkg::VOLT_W-1:0]       out_volts,
  output logic                             out_over,
  output logic                             out_under,
  output logic [acv_pkg::VOLT_W-1:0]       out_deviation,
  output logic                             out_overflow_seen,
  output logic                             out_edge_missing_seen
);
  import acv_pkg::*;

  localparam int POS_W = $clog2(WINDOW_LEN);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW_LEN - 1);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_SRCH = 3'd2;
  localparam logic [2:0] ST_CLS  = 3'd3;
  localparam logic [2:0] ST_TMO  = 3'd4;

  // configuration registers
  logic [VOLT_W-1:0] ref_offset_r;
  logic [VOLT_W-1:0] nominal_r;
  logic [VOLT_W-1:0] high_limit_r;
  logic [VOLT_W-1:0] low_limit_r;
  logic [VAL_W-1:0]  min_period_r;

  // block state
  logic [2:0]        state_r;
  logic [VAL_W-1:0]  win_r [WINDOW_LEN];
  logic [POS_W-1:0]  pos_r;
  logic [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]  sum_nxt;
  logic              over_r;
  logic              under_r;
  logic [VOLT_W-1:0] dev_r;
  logic [1:0]        fault_r;
  logic [VOLT_W-1:0] volts_r;

  // output register
  logic              out_valid_r;
  logic [VOLT_W-1:0] out_volts_r;
  logic              out_over_r;
  logic              out_under_r;
  logic [VOLT_W-1:0] out_dev_r;
  logic [1:0]        out_fault_r;

  logic              accept;
  logic              do_load;
  logic              do_cap;
  logic              do_tmo;
  logic              out_free;
  logic              emit;

  logic              div_done;
  logic [VAL_W-1:0]  div_q;
  logic              srch_done;
  srch_res_t         srch_res;
  logic [VOLT_W-1:0] volts_calc;

  logic              cls_over;
  logic              cls_under;
  logic [VOLT_W-1:0] cls_absdiff;

  // input decode
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign do_load  = accept && (in_cmd == CMD_LOAD) &&
                    ({1'b0, in_index} < (IDX_W+1)'(TABLE_DEPTH));
  assign do_cap   = accept && (in_cmd == CMD_CAPTURE) && (in_value >= min_period_r);
  assign do_tmo   = accept && (in_cmd == CMD_OVERFLOW || in_cmd == CMD_NO_EDGE);
  assign out_free = !out_valid_r || !out_stall;

  // moving sum update
  assign sum_nxt = sum_r - SUM_W'(win_r[pos_r]) + SUM_W'(in_value);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_offset_r <= RST_REF_OFFSET;
      nominal_r    <= RST_NOMINAL;
      high_limit_r <= RST_HIGH_LIMIT;
      low_limit_r  <= RST_LOW_LIMIT;
      min_period_r <= RST_MIN_PERIOD;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REF_OFFSET: ref_offset_r <= cfg_wdata[VOLT_W-1:0];
        CFG_NOMINAL:    nominal_r    <= cfg_wdata[VOLT_W-1:0];
        CFG_HIGH_LIMIT: high_limit_r <= cfg_wdata[VOLT_W-1:0];
        CFG_LOW_LIMIT:  low_limit_r  <= cfg_wdata[VOLT_W-1:0];
        CFG_MIN_PERIOD: min_period_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // divider and table search
  acv_div #(
    .DIVISOR (WINDOW_LEN)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (do_cap),
    .dividend (sum_nxt),
    .done     (div_done),
    .quotient (div_q)
  );

  acv_search #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_search (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (do_load),
    .wr_idx  (in_index),
    .wr_data (in_value),
    .start   (div_done),
    .mean    (div_q),
    .done    (srch_done),
    .res     (srch_res)
  );

  // reading from search outcome, wraps at 8 bits
  assign volts_calc = srch_res.match ?
                      ref_offset_r + VOLT_W'(srch_res.idx) - VOLT_W'(srch_res.rnd_down) :
                      ref_offset_r + VOLT_W'(TABLE_DEPTH);

  // classification against limits
  assign cls_over    = (volts_r > high_limit_r);
  assign cls_under   = !cls_over && (volts_r < low_limit_r);
  assign cls_absdiff = (volts_r >= nominal_r) ? volts_r - nominal_r : nominal_r - volts_r;
  assign emit        = out_free && (state_r == ST_CLS || state_r == ST_TMO);

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pos_r       <= '0;
      sum_r       <= '0;
      over_r      <= 1'b0;
      under_r     <= 1'b0;
      dev_r       <= '0;
      fault_r     <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < WINDOW_LEN; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (do_cap) begin
            sum_r        <= sum_nxt;
            win_r[pos_r] <= in_value;
            pos_r        <= (pos_r == POS_LAST) ? '0 : pos_r + POS_W'(1);
            state_r      <= ST_DIV;
          end else if (do_tmo) begin
            fault_r <= fault_r | ((in_cmd == CMD_OVERFLOW) ? 2'b01 : 2'b10);
            state_r <= ST_TMO;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_SRCH;
          end
        end
        ST_SRCH: begin
          if (srch_done) begin
            state_r <= ST_CLS;
          end
        end
        ST_CLS: begin
          if (out_free) begin
            over_r  <= cls_over;
            under_r <= cls_under;
            if (cls_over || cls_under) begin
              dev_r <= cls_absdiff;
            end
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        ST_TMO: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // reading register
  always_ff @(posedge clk) begin
    if (srch_done) begin
      volts_r <= volts_calc;
    end else if (do_tmo) begin
      volts_r <= TIMEOUT_VOLTS;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (emit) begin
      out_volts_r <= volts_r;
      out_fault_r <= fault_r;
      if (state_r == ST_CLS) begin
        out_over_r  <= cls_over;
        out_under_r <= cls_under;
        out_dev_r   <= (cls_over || cls_under) ? cls_absdiff : '0;
      end else begin
        out_over_r  <= over_r;
        out_under_r <= under_r;
        out_dev_r   <= (over_r || under_r) ? dev_r : '0;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_volts             = out_volts_r;
  assign out_over              = out_over_r;
  assign out_under             = out_under_r;
  assign out_deviation         = out_dev_r;
  assign out_overflow_seen     = out_fault_r[0];
  assign out_edge_missing_seen = out_fault_r[1];

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// testbench for the ac voltage period classifier: random and directed items against a predictor
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import acv_pkg::*;

  localparam int TBL_DEPTH    = 100;
  localparam int WIN_LEN      = 10;
  localparam int DRAIN_CYCLES = 160;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [IDX_W-1:0] idx;
    logic [VAL_W-1:0] value;
  } cmd_item_t;

  typedef struct packed {
    logic [VOLT_W-1:0] volts;
    logic              over;
    logic              under;
    logic [VOLT_W-1:0] deviation;
    logic              overflow_seen;
    logic              edge_missing_seen;
  } reading_t;

  typedef enum {TBL_RAMP, TBL_EVEN, TBL_SCRAMBLE} tbl_shape_t;

  // dut ports
  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               cfg_we     = 1'b0;
  logic [CFG_IW-1:0]  cfg_index  = '0;
  logic [CFG_DW-1:0]  cfg_wdata  = '0;
  logic               in_valid   = 1'b0;
  logic               in_stall;
  logic [CMD_W-1:0]   in_cmd     = '0;
  logic [IDX_W-1:0]   in_index   = '0;
  logic [VAL_W-1:0]   in_value   = '0;
  logic               out_valid;
  logic               out_stall  = 1'b0;
  logic [VOLT_W-1:0]  out_volts;
  logic               out_over;
  logic               out_under;
  logic [VOLT_W-1:0]  out_deviation;
  logic               out_overflow_seen;
  logic               out_edge_missing_seen;

  // predictor state and its copy of the registers
  logic [VAL_W-1:0]   cal_tbl [TBL_DEPTH];
  logic [VAL_W-1:0]   win_buf [WIN_LEN];
  int unsigned        win_ptr;
  logic [SUM_W-1:0]   win_total;
  logic               flag_over;
  logic               flag_under;
  logic [VOLT_W-1:0]  last_dev;
  logic [1:0]         fault_bits;
  logic [VOLT_W-1:0]  p_offset;
  logic [VOLT_W-1:0]  p_nominal;
  logic [VOLT_W-1:0]  p_high;
  logic [VOLT_W-1:0]  p_low;
  logic [VAL_W-1:0]   p_min_period;

  // item queues and bookkeeping
  cmd_item_t          cmd_backlog[$];
  reading_t           readings_due[$];
  bit                 steady;
  int unsigned        gap_left;
  int unsigned        stall_left;
  int                 mismatch_cnt;
  int                 n_checked;
  int                 n_loads;
  int                 n_captures;
  int                 n_timeouts;
  int                 n_over;
  int                 n_under;
  int                 cyc;

  // stimulus shaping
  int                 gen_tbl [TBL_DEPTH];
  int                 gen_lo;
  int                 gen_hi;

  ac_voltage_period_classifier_top #(
    .TABLE_DEPTH(TBL_DEPTH),
    .WINDOW_LEN (WIN_LEN)
  ) i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_cmd               (in_cmd),
    .in_index             (in_index),
    .in_value             (in_value),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_volts            (out_volts),
    .out_over             (out_over),
    .out_under            (out_under),
    .out_deviation        (out_deviation),
    .out_overflow_seen    (out_overflow_seen),
    .out_edge_missing_seen(out_edge_missing_seen)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // idle cycles before an item and stall cycles after a reading, none in steady phases
  function automatic int unsigned pause_len();
    return steady ? 0 : $urandom_range(0, 6);
  endfunction

  // first table entry at or above the mean, rounded to the nearer neighbor
  function automatic logic [VOLT_W-1:0] table_volts(input int unsigned mean);
    logic [VOLT_W-1:0] v;
    int i;
    for (i = 0; i < TBL_DEPTH; i++) begin
      if (mean <= cal_tbl[i]) begin
        v = p_offset + VOLT_W'(i);
        if (i > 0) begin
          if ((cal_tbl[i] - mean) > (mean - cal_tbl[i-1])) v = v - 8'd1;
        end
        return v;
      end
    end
    v = p_offset + VOLT_W'(TBL_DEPTH);
    return v;
  endfunction

  // update the predicted state for one item, returns 1 when a reading follows
  function automatic bit predict_reading(input cmd_item_t it, output reading_t rd);
    logic [VOLT_W-1:0] v;
    rd = '0;
    case (it.cmd)
      CMD_LOAD: begin
        if (it.idx < TBL_DEPTH) cal_tbl[it.idx] = it.value;
        return 1'b0;
      end
      CMD_CAPTURE: begin
        if (it.value < p_min_period) return 1'b0;
        win_total = win_total - win_buf[win_ptr] + it.value;
        win_buf[win_ptr] = it.value;
        win_ptr = (win_ptr + 1 == WIN_LEN) ? 0 : win_ptr + 1;
        v = table_volts(win_total / WIN_LEN);
        if (v > p_high) begin
          flag_over  = 1'b1;
          flag_under = 1'b0;
          last_dev   = (v >= p_nominal) ? v - p_nominal : p_nominal - v;
        end else if (v < p_low) begin
          flag_over  = 1'b0;
          flag_under = 1'b1;
          last_dev   = (v >= p_nominal) ? v - p_nominal : p_nominal - v;
        end else begin
          flag_over  = 1'b0;
          flag_under = 1'b0;
        end
      end
      default: begin
        v = TIMEOUT_VOLTS;
        if (it.cmd == CMD_OVERFLOW) fault_bits[0] = 1'b1;
        else fault_bits[1] = 1'b1;
      end
    endcase
    rd.volts             = v;
    rd.over              = flag_over;
    rd.under             = flag_under;
    rd.deviation         = (flag_over || flag_under) ? last_dev : '0;
    rd.overflow_seen     = fault_bits[0];
    rd.edge_missing_seen = fault_bits[1];
    return 1'b1;
  endfunction

  task automatic note_mismatch(input string what, input int got, input int want);
    mismatch_cnt++;
    if (mismatch_cnt <= 40)
      $display("%0t ns reading %0d: %s is %0d, predicted %0d", $time, n_checked, what, got, want);
  endtask

  task automatic check_field(input string what, input int got, input int want);
    if (got != want) note_mismatch(what, got, want);
  endtask

  // put the next pending item on the input port
  task present_next();
    cmd_item_t nx;
    nx = cmd_backlog.pop_front();
    in_cmd   <= nx.cmd;
    in_index <= nx.idx;
    in_value <= nx.value;
    in_valid <= 1'b1;
  endtask

  // input driver, predicts at acceptance
  always @(posedge clk) begin : drive_items
    cmd_item_t   taken;
    reading_t    rd;
    bit          has_rd;
    int unsigned g;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else if (in_valid && !in_stall) begin
      taken.cmd   = in_cmd;
      taken.idx   = in_index;
      taken.value = in_value;
      if (in_cmd == CMD_LOAD) n_loads++;
      else if (in_cmd == CMD_CAPTURE) n_captures++;
      else n_timeouts++;
      has_rd = predict_reading(taken, rd);
      if (has_rd) readings_due.push_back(rd);
      g = pause_len();
      if (g == 0 && cmd_backlog.size() != 0) begin
        present_next();
      end else begin
        in_valid <= 1'b0;
        gap_left <= g;
      end
    end else if (!in_valid) begin
      if (gap_left != 0) gap_left <= gap_left - 1;
      else if (cmd_backlog.size() != 0) present_next();
    end
  end

  // result monitor with random backpressure
  always @(posedge clk) begin : watch_readings
    reading_t    want;
    int unsigned g;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      n_checked++;
      if (readings_due.size() == 0) begin
        note_mismatch("unexpected reading, volts", out_volts, -1);
      end else begin
        want = readings_due.pop_front();
        if (want.over) n_over++;
        if (want.under) n_under++;
        check_field("volts", out_volts, want.volts);
        check_field("over", out_over, want.over);
        check_field("under", out_under, want.under);
        check_field("deviation", out_deviation, want.deviation);
        check_field("overflow_seen", out_overflow_seen, want.overflow_seen);
        check_field("edge_missing_seen", out_edge_missing_seen, want.edge_missing_seen);
      end
      g = pause_len();
      out_stall  <= (g != 0);
      stall_left <= g;
    end else if (out_stall && out_valid) begin
      if (stall_left <= 1) out_stall <= 1'b0;
      stall_left <= stall_left - 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cyc++;
    if (cyc >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d readings still due", cyc, readings_due.size());
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_cmd(input logic [CMD_W-1:0] c, input logic [IDX_W-1:0] ix,
                          input logic [VAL_W-1:0] val);
    cmd_item_t it;
    it.cmd   = c;
    it.idx   = ix;
    it.value = val;
    cmd_backlog.push_back(it);
  endtask

  // register write, the predictor copy follows at once since the block is idle
  task automatic write_reg(input logic [CFG_IW-1:0] ri, input logic [CFG_DW-1:0] d);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= ri;
    cfg_wdata <= d;
    case (ri)
      CFG_REF_OFFSET: p_offset     = d[VOLT_W-1:0];
      CFG_NOMINAL:    p_nominal    = d[VOLT_W-1:0];
      CFG_HIGH_LIMIT: p_high       = d[VOLT_W-1:0];
      CFG_LOW_LIMIT:  p_low        = d[VOLT_W-1:0];
      CFG_MIN_PERIOD: p_min_period = d;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int off, input int nom, input int hi, input int lo,
                                input int minp);
    write_reg(CFG_REF_OFFSET, CFG_DW'(off));
    write_reg(CFG_NOMINAL, CFG_DW'(nom));
    write_reg(CFG_HIGH_LIMIT, CFG_DW'(hi));
    write_reg(CFG_LOW_LIMIT, CFG_DW'(lo));
    write_reg(CFG_MIN_PERIOD, CFG_DW'(minp));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // band around a nominal that sits inside the table's reading range
  task automatic random_settings();
    int off, nom, hi, lo;
    off = $urandom_range(0, 155);
    nom = off + $urandom_range(0, 99);
    if (nom > 255) nom = 255;
    hi = nom + $urandom_range(0, 8);
    if (hi > 255) hi = 255;
    lo = nom - $urandom_range(0, 8);
    if (lo < 0) lo = 0;
    apply_settings(off, nom, hi, lo, $urandom_range(0, gen_lo));
  endtask

  task automatic build_table(input int base, input int max_step, input tbl_shape_t shape);
    int acc, i;
    acc    = base;
    gen_lo = 65535;
    gen_hi = 0;
    for (i = 0; i < TBL_DEPTH; i++) begin
      if (shape == TBL_SCRAMBLE) gen_tbl[i] = $urandom_range(0, 65535);
      else gen_tbl[i] = (acc > 65535) ? 65535 : acc;
      if (gen_tbl[i] < gen_lo) gen_lo = gen_tbl[i];
      if (gen_tbl[i] > gen_hi) gen_hi = gen_tbl[i];
      acc = acc + ((shape == TBL_EVEN) ? max_step : $urandom_range(0, max_step));
    end
  endtask

  task automatic queue_table();
    int i;
    for (i = 0; i < TBL_DEPTH; i++) push_cmd(CMD_LOAD, IDX_W'(i), VAL_W'(gen_tbl[i]));
  endtask

  // captures from a drifting level, with timeouts, glitches and stray loads
  task automatic queue_captures(input int n);
    int k, pick, span, lvl, d, j, v, step;
    span = gen_hi - gen_lo + 1;
    d    = span / 40 + 1;
    j    = span / 100 + 1;
    lvl  = gen_lo + $urandom_range(0, span - 1);
    for (k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        push_cmd(CMD_OVERFLOW, IDX_W'($urandom_range(0, 127)),
                 VAL_W'($urandom_range(0, 65535)));
      end else if (pick < 6) begin
        push_cmd(CMD_NO_EDGE, IDX_W'($urandom_range(0, 127)),
                 VAL_W'($urandom_range(0, 65535)));
      end else if (pick < 9) begin
        push_cmd(CMD_LOAD, IDX_W'($urandom_range(0, 127)),
                 VAL_W'($urandom_range(0, 65535)));
      end else if (pick < 14) begin
        v = (p_min_period == 0) ? $urandom_range(0, 65535) : $urandom_range(0, p_min_period - 1);
        push_cmd(CMD_CAPTURE, IDX_W'($urandom_range(0, 127)), VAL_W'(v));
      end else begin
        if ($urandom_range(0, 19) == 0) begin
          lvl = gen_lo - span / 4 + $urandom_range(0, span * 3 / 2);
        end else begin
          step = $urandom_range(0, 2 * d);
          lvl  = lvl + step - d;
        end
        if (lvl < 0) lvl = 0;
        if (lvl > 65535) lvl = 65535;
        step = $urandom_range(0, 2 * j);
        v = lvl + step - j;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        // most captures clear the glitch filter
        if (v < p_min_period && $urandom_range(0, 3) != 0)
          v = p_min_period + $urandom_range(0, 65535 - p_min_period) / 64;
        push_cmd(CMD_CAPTURE, IDX_W'($urandom_range(0, 127)), VAL_W'(v));
      end
    end
  endtask

  // wait until every item is taken and every reading has come back
  task automatic drain();
    while (cmd_backlog.size() != 0 || in_valid || readings_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // sequence of phases
  initial begin : run_phases
    int i, k, ph, off;
    for (i = 0; i < TBL_DEPTH; i++) cal_tbl[i] = '0;
    for (i = 0; i < WIN_LEN; i++) win_buf[i] = '0;
    win_ptr      = 0;
    win_total    = '0;
    flag_over    = 1'b0;
    flag_under   = 1'b0;
    last_dev     = '0;
    fault_bits   = '0;
    p_offset     = RST_REF_OFFSET;
    p_nominal    = RST_NOMINAL;
    p_high       = RST_HIGH_LIMIT;
    p_low        = RST_LOW_LIMIT;
    p_min_period = RST_MIN_PERIOD;
    steady       = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed items on reset settings, even table 800..1592
    build_table(800, 8, TBL_EVEN);
    queue_table();
    push_cmd(CMD_LOAD, 127, 16'hFFFF);
    push_cmd(CMD_LOAD, 100, 16'h0000);
    push_cmd(CMD_CAPTURE, 0, 0);
    push_cmd(CMD_CAPTURE, 5, 767);
    push_cmd(CMD_CAPTURE, 127, 768);
    push_cmd(CMD_OVERFLOW, 0, 0);
    push_cmd(CMD_CAPTURE, 64, 16'hFFFF);
    push_cmd(CMD_NO_EDGE, 127, 16'hFFFF);
    push_cmd(CMD_CAPTURE, 1, 16'hFFFF);
    for (k = 0; k < 8; k++) push_cmd(CMD_CAPTURE, IDX_W'(k), VAL_W'(1200 + 2 * k));
    for (k = 0; k < 6; k++) push_cmd(CMD_CAPTURE, IDX_W'(100 + k), 1352);
    drain();

    // random phases with different settings and tables
    for (ph = 1; ph <= 10; ph++) begin
      steady = (ph == 1 || ph == 6);
      case (ph)
        1: begin
          build_table(0, 3, TBL_RAMP);
          apply_settings(0, 0, 255, 0, 0);
        end
        2: begin
          build_table(60000, 50, TBL_RAMP);
          apply_settings(155, 255, 0, 255, 65535);
        end
        3: begin
          // low limit above high limit
          build_table($urandom_range(0, 40000), $urandom_range(1, 200), TBL_RAMP);
          off = $urandom_range(0, 150);
          apply_settings(off, off + 50, off + 45, off + 55, $urandom_range(0, gen_lo));
        end
        4: begin
          build_table(0, 0, TBL_SCRAMBLE);
          random_settings();
        end
        7: begin
          build_table($urandom_range(0, 40000), $urandom_range(1, 200), TBL_RAMP);
          random_settings();
        end
        default: random_settings();
      endcase
      if (ph <= 4 || ph == 7) queue_table();
      queue_captures(78);
      drain();
    end

    $display("items taken: %0d loads, %0d captures, %0d timeouts over 11 phases",
             n_loads, n_captures, n_timeouts);
    $display("readings checked: %0d (%0d over, %0d under)", n_checked, n_over, n_under);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
